FILE: rtl/core/aivm_pkg.sv
package aivm_pkg;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned CHUNK_W = 7;
    localparam int unsigned STAT_W  = 3;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 7'd8;

    localparam logic [KIND_W-1:0] KIND_LOAD        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORE       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT_CHUNK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT_ALL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET       = 3'd4;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] ST_EVICTED  = 3'd5;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd6;
    localparam logic [STAT_W-1:0] ST_RESET    = 3'd7;

    // Controller to datapath.
    typedef struct packed {
        logic              capture;
        logic              match;
        logic              load_rd;
        logic              store;
        logic              clear_all;
        logic              ev_read;
        logic              emit;
        logic [STAT_W-1:0] code;
        logic              last;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              full;
        logic              rem_zero;
    } t_stat;

endpackage

FILE: rtl/core/aivm_dpath.sv
module aivm_dpath #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aivm_pkg::CHUNK_W-1:0]      i_cfg_wdata,
    input  logic [aivm_pkg::KIND_W-1:0]       i_kind,
    input  logic [aivm_pkg::DATA_W-1:0]       i_index,
    input  logic [aivm_pkg::DATA_W-1:0]       i_value,
    input  aivm_pkg::t_cmd                    i_cmd,
    output aivm_pkg::t_stat                   o_stat,
    output logic [aivm_pkg::STAT_W-1:0]       o_status,
    output logic [aivm_pkg::DATA_W-1:0]       o_out_index,
    output logic [aivm_pkg::DATA_W-1:0]       o_out_value,
    output logic                              o_last,
    output logic [aivm_pkg::COUNT_W-1:0]      o_valid_count
);

    localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    function automatic logic [SW-1:0] f_lowest(input logic [CAPACITY-1:0] vec);
        logic [SW-1:0] pos;
        pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (vec[i]) pos = SW'(i);
        end
        return pos;
    endfunction

    // key cells for the parallel compare
    logic [aivm_pkg::DATA_W-1:0] r_key [CAPACITY];
    logic [CAPACITY-1:0]         r_valid;
    logic [CAPACITY-1:0]         r_match;
    // key copy and values, read back at one address
    logic [aivm_pkg::DATA_W-1:0] mem_key [CAPACITY];
    logic [aivm_pkg::DATA_W-1:0] mem_val [CAPACITY];
    logic [aivm_pkg::DATA_W-1:0] r_rd_key;
    logic [aivm_pkg::DATA_W-1:0] r_rd_val;

    logic [aivm_pkg::KIND_W-1:0]  r_kind;
    logic [aivm_pkg::DATA_W-1:0]  r_index;
    logic [aivm_pkg::DATA_W-1:0]  r_value;
    logic [aivm_pkg::CHUNK_W-1:0] r_chunk;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_remain;

    logic [aivm_pkg::STAT_W-1:0]  r_out_status;
    logic [aivm_pkg::DATA_W-1:0]  r_out_index;
    logic [aivm_pkg::DATA_W-1:0]  r_out_value;
    logic                         r_out_last;
    logic [aivm_pkg::COUNT_W-1:0] r_out_count;

    logic [SW-1:0] hit_slot;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] ev_slot;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] wr_addr;
    logic          hit;
    logic          full;
    logic [CW-1:0] lim;
    logic [CW-1:0] target;

    assign hit       = |r_match;
    assign full      = (r_count == CW'(CAPACITY));
    assign hit_slot  = f_lowest(r_match);
    assign free_slot = f_lowest(~r_valid);
    assign ev_slot   = f_lowest(r_valid);
    assign rd_addr   = i_cmd.ev_read ? ev_slot : hit_slot;
    assign wr_addr   = hit ? hit_slot : free_slot;

    always_comb begin
        if (r_kind == aivm_pkg::KIND_EVICT_ALL) begin
            lim = CW'(CAPACITY);
        end else if (r_chunk > aivm_pkg::CHUNK_W'(CAPACITY)) begin
            lim = CW'(CAPACITY);
        end else begin
            lim = CW'(r_chunk);
        end
        target = (lim < r_count) ? lim : r_count;
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.hit      = hit;
    assign o_stat.full     = full;
    assign o_stat.rem_zero = (r_remain == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_chunk  <= aivm_pkg::CHUNK_RESET;
        end else begin
            if (i_cfg_we) r_chunk <= i_cfg_wdata;
            if (i_cmd.match) r_remain <= target;
            if (i_cmd.store && !hit && !full) begin
                r_valid[free_slot] <= 1'b1;
                r_count            <= r_count + 1'b1;
            end
            if (i_cmd.ev_read) begin
                r_valid[ev_slot] <= 1'b0;
                r_count          <= r_count - 1'b1;
                r_remain         <= r_remain - 1'b1;
            end
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_index <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= r_valid[i] && (r_key[i] == r_index);
            end
        end
        if (i_cmd.store && !hit && !full) begin
            r_key[free_slot] <= r_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (hit || !full)) begin
            mem_val[wr_addr] <= r_value;
        end
        if (i_cmd.store && !hit && !full) begin
            mem_key[free_slot] <= r_index;
        end
        if (i_cmd.load_rd || i_cmd.ev_read) begin
            r_rd_val <= mem_val[rd_addr];
            r_rd_key <= mem_key[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.code;
            r_out_last   <= i_cmd.last;
            r_out_count  <= aivm_pkg::COUNT_W'(r_count);
            r_out_index  <= (i_cmd.code == aivm_pkg::ST_EVICTED) ? r_rd_key : r_index;
            if (i_cmd.code == aivm_pkg::ST_HIT || i_cmd.code == aivm_pkg::ST_EVICTED) begin
                r_out_value <= r_rd_val;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_status      = r_out_status;
    assign o_out_index   = r_out_index;
    assign o_out_value   = r_out_value;
    assign o_last        = r_out_last;
    assign o_valid_count = r_out_count;

endmodule

FILE: rtl/core/aivm_ctrl.sv
module aivm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  aivm_pkg::t_stat i_stat,
    output aivm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_EMIT,
        S_EV_READ,
        S_EV_EMIT
    } t_state;

    t_state                      r_state, n_state;
    logic [aivm_pkg::STAT_W-1:0] r_code, n_code;
    logic                        r_out_valid;
    logic                        out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                // drop unknown kinds without a result
                if (i_stat.kind > aivm_pkg::KIND_RESET) n_state = S_IDLE;
                else n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.kind) inside
                    aivm_pkg::KIND_LOAD: begin
                        o_cmd.load_rd = 1'b1;
                        n_code  = i_stat.hit ? aivm_pkg::ST_HIT : aivm_pkg::ST_MISS;
                        n_state = S_EMIT;
                    end
                    aivm_pkg::KIND_STORE: begin
                        o_cmd.store = 1'b1;
                        if (i_stat.hit) n_code = aivm_pkg::ST_UPDATED;
                        else if (i_stat.full) n_code = aivm_pkg::ST_FULL;
                        else n_code = aivm_pkg::ST_INSERTED;
                        n_state = S_EMIT;
                    end
                    aivm_pkg::KIND_EVICT_CHUNK, aivm_pkg::KIND_EVICT_ALL: begin
                        if (i_stat.rem_zero) begin
                            n_code  = aivm_pkg::ST_NONE;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_EV_READ;
                        end
                    end
                    aivm_pkg::KIND_RESET: begin
                        o_cmd.clear_all = 1'b1;
                        n_code  = aivm_pkg::ST_RESET;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = r_code;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EV_READ: begin
                o_cmd.ev_read = 1'b1;
                n_state       = S_EV_EMIT;
            end
            S_EV_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = aivm_pkg::ST_EVICTED;
                    o_cmd.last = i_stat.rem_zero;
                    n_state    = i_stat.rem_zero ? S_IDLE : S_EV_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= aivm_pkg::ST_HIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if (o_cmd.emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/associative_index_value_map.sv
// Load, store, reset and empty evict go through the match, execute and emit states; emit
// waits while the output is stalled. A new request is taken only in idle. An eviction
// alternates read and emit states per pair after execute, set by the one read port of the
// key/value memories. Unknown kinds are dropped after the match state without a result.
// Reset (i_rst_n, synchronous) clears every valid mark and the pair count,
// and returns evict_chunk to 8; there is no clearing pass.
module associative_index_value_map #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: evict_chunk
    input  logic                         i_cfg_we,
    input  logic [aivm_pkg::CHUNK_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [aivm_pkg::KIND_W-1:0]  i_kind,
    input  logic [aivm_pkg::DATA_W-1:0]  i_index,
    input  logic [aivm_pkg::DATA_W-1:0]  i_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [aivm_pkg::STAT_W-1:0]  o_status,
    output logic [aivm_pkg::DATA_W-1:0]  o_out_index,
    output logic [aivm_pkg::DATA_W-1:0]  o_out_value,
    output logic                         o_last,
    output logic [aivm_pkg::COUNT_W-1:0] o_valid_count
);

    // The controller sequences each transaction: capture, parallel key compare,
    // act on the match/free vectors, then hand the result to the output register.
    // The datapath holds the key cells, valid marks, value memories and the count.
    aivm_pkg::t_cmd  cmd;
    aivm_pkg::t_stat stat;

    aivm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    aivm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_out_index   (o_out_index),
        .o_out_value   (o_out_value),
        .o_last        (o_last),
        .o_valid_count (o_valid_count)
    );

endmodule

FILE: tb/aivm_checker.sv
module aivm_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [aivm_pkg::CHUNK_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [aivm_pkg::KIND_W-1:0]  i_kind,
    input  logic [aivm_pkg::DATA_W-1:0]  i_index,
    input  logic [aivm_pkg::DATA_W-1:0]  i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [aivm_pkg::STAT_W-1:0]  i_status,
    input  logic [aivm_pkg::DATA_W-1:0]  i_out_index,
    input  logic [aivm_pkg::DATA_W-1:0]  i_out_value,
    input  logic                         i_last,
    input  logic [aivm_pkg::COUNT_W-1:0] i_valid_count,
    output int unsigned                  o_mismatches,
    output int unsigned                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [aivm_pkg::STAT_W-1:0]  status;
        logic [aivm_pkg::DATA_W-1:0]  index;
        logic [aivm_pkg::DATA_W-1:0]  value;
        logic                         last;
        logic [aivm_pkg::COUNT_W-1:0] count;
    } t_map_result;

    // Shadow copy of the table and of the evict_chunk register.
    logic [aivm_pkg::DATA_W-1:0]  slot_key   [CAPACITY];
    logic [aivm_pkg::DATA_W-1:0]  slot_value [CAPACITY];
    logic [CAPACITY-1:0]          slot_live;
    logic [aivm_pkg::CHUNK_W-1:0] chunk_limit;

    t_map_result expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void queue_result(input logic [aivm_pkg::STAT_W-1:0] status,
                                         input logic [aivm_pkg::DATA_W-1:0] index,
                                         input logic [aivm_pkg::DATA_W-1:0] value,
                                         input logic                        last);
        t_map_result r;
        r.status = status;
        r.index  = index;
        r.value  = value;
        r.last   = last;
        r.count  = aivm_pkg::COUNT_W'($countones(slot_live));
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Lowest live slot holding the key, or -1.
    function automatic int find_slot(input logic [aivm_pkg::DATA_W-1:0] key);
        for (int s = 0; s < CAPACITY; s++) begin
            if (slot_live[s] && slot_key[s] == key) begin
                return s;
            end
        end
        return -1;
    endfunction

    // Drain up to limit live pairs, lowest slot first.
    function automatic void drain_pairs(input int unsigned limit,
                                        input logic [aivm_pkg::DATA_W-1:0] echo);
        int unsigned target;
        int unsigned taken;
        target = $countones(slot_live);
        if (limit < target) begin
            target = limit;
        end
        taken = 0;
        if (target == 0) begin
            queue_result(aivm_pkg::ST_NONE, echo, '0, 1'b1);
        end else begin
            for (int s = 0; s < CAPACITY && taken < target; s++) begin
                if (slot_live[s]) begin
                    slot_live[s] = 1'b0;
                    taken++;
                    queue_result(aivm_pkg::ST_EVICTED, slot_key[s], slot_value[s],
                                 taken == target);
                end
            end
        end
    endfunction

    function automatic void predict_request(input logic [aivm_pkg::KIND_W-1:0] kind,
                                            input logic [aivm_pkg::DATA_W-1:0] index,
                                            input logic [aivm_pkg::DATA_W-1:0] value);
        int slot;
        int unsigned chunk;
        case (kind)
            aivm_pkg::KIND_LOAD: begin
                slot = find_slot(index);
                if (slot >= 0) begin
                    queue_result(aivm_pkg::ST_HIT, index, slot_value[slot], 1'b1);
                end else begin
                    queue_result(aivm_pkg::ST_MISS, index, '0, 1'b1);
                end
            end
            aivm_pkg::KIND_STORE: begin
                slot = find_slot(index);
                if (slot >= 0) begin
                    slot_value[slot] = value;
                    queue_result(aivm_pkg::ST_UPDATED, index, '0, 1'b1);
                end else begin
                    for (int s = CAPACITY - 1; s >= 0; s--) begin
                        if (!slot_live[s]) begin
                            slot = s;
                        end
                    end
                    if (slot < 0) begin
                        queue_result(aivm_pkg::ST_FULL, index, '0, 1'b1);
                    end else begin
                        slot_key[slot]   = index;
                        slot_value[slot] = value;
                        slot_live[slot]  = 1'b1;
                        queue_result(aivm_pkg::ST_INSERTED, index, '0, 1'b1);
                    end
                end
            end
            aivm_pkg::KIND_EVICT_CHUNK: begin
                chunk = (chunk_limit > CAPACITY) ? CAPACITY : chunk_limit;
                drain_pairs(chunk, index);
            end
            aivm_pkg::KIND_EVICT_ALL: begin
                drain_pairs(CAPACITY, index);
            end
            aivm_pkg::KIND_RESET: begin
                slot_live = '0;
                queue_result(aivm_pkg::ST_RESET, index, '0, 1'b1);
            end
            default: begin
                // spare kinds: dropped without a result
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_map_result want;
        if (!i_rst_n) begin
            slot_live   = '0;
            chunk_limit = aivm_pkg::CHUNK_RESET;
            expected_results.delete();
        end else begin
            // A result always leaves after its request is taken, so check first.
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result %0d: status %0d index %08h value %08h last %0b count %0d",
                        results_seen, i_status, i_out_index, i_out_value, i_last,
                        i_valid_count));
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status || i_out_index !== want.index ||
                        i_out_value !== want.value || i_last !== want.last ||
                        i_valid_count !== want.count) begin
                        note_failure($sformatf(
                            {"result %0d mismatch: expected status %0d index %08h value %08h",
                             " last %0b count %0d, got status %0d index %08h value %08h",
                             " last %0b count %0d"},
                            results_seen, want.status, want.index, want.value, want.last,
                            want.count, i_status, i_out_index, i_out_value, i_last,
                            i_valid_count));
                    end
                end
            end
            if (i_cfg_we) begin
                chunk_limit = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_kind, i_index, i_value);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_results.size();
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY       = 64;
    localparam int unsigned HOLD_OFF       = 8;     // covers the request-to-result latency
    localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
    localparam int unsigned KEY_POOL       = 96;    // more keys than slots, so the table fills
    localparam int unsigned SEGMENT_ITEMS  = 26;
    localparam int unsigned SEGMENTS       = 6;

    // Kinds the block ignores.
    localparam logic [aivm_pkg::KIND_W-1:0] KIND_IGNORED_LOW  = 3'd5;
    localparam logic [aivm_pkg::KIND_W-1:0] KIND_IGNORED_HIGH = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [aivm_pkg::CHUNK_W-1:0]   i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [aivm_pkg::KIND_W-1:0]    i_kind;
    logic [aivm_pkg::DATA_W-1:0]    i_index;
    logic [aivm_pkg::DATA_W-1:0]    i_value;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [aivm_pkg::STAT_W-1:0]    o_status;
    logic [aivm_pkg::DATA_W-1:0]    o_out_index;
    logic [aivm_pkg::DATA_W-1:0]    o_out_value;
    logic                           o_last;
    logic [aivm_pkg::COUNT_W-1:0]   o_valid_count;

    int unsigned                    mismatch_total;
    int unsigned                    results_outstanding;
    int unsigned                    quiet_cycles = 0;
    int unsigned                    send_idle_pct = 0;
    int unsigned                    recv_idle_pct = 0;

    logic [aivm_pkg::DATA_W-1:0]    key_pool [KEY_POOL];
    logic [aivm_pkg::DATA_W-1:0]    stored_keys[$];      // recent store keys, so loads can hit
    logic [aivm_pkg::CHUNK_W-1:0]   chunk_plan [SEGMENTS];

    associative_index_value_map #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .o_valid_count(o_valid_count)
    );

    aivm_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_out_index  (o_out_index),
        .i_out_value  (o_out_value),
        .i_last       (o_last),
        .i_valid_count(o_valid_count),
        .o_mismatches (mismatch_total),
        .o_outstanding(results_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver back-pressure: stall at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a hung block or a lost result ends here.
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one request and hold it until the block takes it. Idle first at random,
    // so gaps fall on every phase of the block's work.
    task automatic send_request(input logic [aivm_pkg::KIND_W-1:0] kind,
                                input logic [aivm_pkg::DATA_W-1:0] index,
                                input logic [aivm_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_index    <= index;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == aivm_pkg::KIND_STORE) begin
            stored_keys.insert(stored_keys.size(), index);
            if (stored_keys.size() > 16) begin
                void'(stored_keys.pop_front());
            end
        end
    endtask

    // Drop valid and wait until every predicted result has come back, then hold off
    // long enough for a dropped spare-kind request to leave the pipeline.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // Only call while the block is idle.
    task automatic write_chunk(input logic [aivm_pkg::CHUNK_W-1:0] chunk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= chunk;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Keys mostly from the pool so that stores collide and loads hit; some extremes
    // and some fully random ones.
    function automatic logic [aivm_pkg::DATA_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80) begin
            return key_pool[$urandom_range(KEY_POOL - 1)];
        end
        if (roll < 90) begin
            return roll[0] ? '1 : '0;
        end
        return $urandom;
    endfunction

    // One random segment. A fill segment first stores more distinct pool keys than
    // there are slots, so the table fills and reports full.
    task automatic run_mix(input int unsigned items, input bit fill_first);
        int unsigned issued;
        int unsigned roll;
        int unsigned base;
        logic [aivm_pkg::DATA_W-1:0] key;
        issued = 0;
        if (fill_first) begin
            base = $urandom_range(KEY_POOL - 1);
            for (int n = 0; n < CAPACITY + 2; n++) begin
                send_request(aivm_pkg::KIND_STORE, key_pool[(base + n) % KEY_POOL],
                             $urandom);
            end
        end
        while (issued < items) begin
            // Now and then pause until every result is back.
            if ($urandom_range(99) < 2) begin
                wait_drained();
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                // Ignored kinds: noise, not counted.
                send_request(aivm_pkg::KIND_W'($urandom_range(KIND_IGNORED_HIGH,
                                                              KIND_IGNORED_LOW)),
                             $urandom, $urandom);
            end else begin
                issued++;
                if (roll < 44) begin
                    send_request(aivm_pkg::KIND_STORE, pick_key(), $urandom);
                end else if (roll < 78) begin
                    if (stored_keys.size() != 0 && $urandom_range(99) < 60) begin
                        key = stored_keys[$urandom_range(stored_keys.size() - 1)];
                    end else begin
                        key = pick_key();
                    end
                    send_request(aivm_pkg::KIND_LOAD, key, $urandom);
                end else if (roll < 90) begin
                    send_request(aivm_pkg::KIND_EVICT_CHUNK, $urandom, $urandom);
                end else if (roll < 97) begin
                    send_request(aivm_pkg::KIND_EVICT_ALL, $urandom, $urandom);
                end else begin
                    send_request(aivm_pkg::KIND_RESET, $urandom, $urandom);
                end
            end
        end
    endtask

    initial begin
        // Hold every input at a known value from time zero.
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= aivm_pkg::KIND_LOAD;
        i_index     <= '0;
        i_value     <= '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < KEY_POOL; k++) begin
            key_pool[k] = $urandom;
        end
        chunk_plan = '{aivm_pkg::CHUNK_W'(1), aivm_pkg::CHUNK_W'(CAPACITY),
                       aivm_pkg::CHUNK_W'($urandom_range(63, 2)), aivm_pkg::CHUNK_W'(0),
                       aivm_pkg::CHUNK_W'(3), aivm_pkg::CHUNK_W'($urandom_range(127, 65))};

        // Phase one: sender idles lightly, receiver stalls heavily.
        send_idle_pct = 28;
        recv_idle_pct = 55;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, evict_chunk at its reset value of eight.
        send_request(aivm_pkg::KIND_LOAD, '0, '1);               // miss on the empty table
        send_request(aivm_pkg::KIND_EVICT_CHUNK, '1, '1);        // nothing to evict, index echoed
        send_request(aivm_pkg::KIND_EVICT_ALL, 32'h5a5a_a5a5, '0);
        send_request(aivm_pkg::KIND_STORE, '0, '1);              // insert at slot zero
        send_request(aivm_pkg::KIND_STORE, '1, '0);              // insert the top key
        send_request(aivm_pkg::KIND_STORE, '0, 32'h3f80_0000);   // update in place
        send_request(aivm_pkg::KIND_LOAD, '0, '0);               // hit
        send_request(aivm_pkg::KIND_LOAD, '1, '1);               // hit with value zero
        send_request(aivm_pkg::KIND_LOAD, 32'h0000_0005, '0);    // miss
        for (int k = 1; k <= 6; k++) begin
            send_request(aivm_pkg::KIND_STORE, aivm_pkg::DATA_W'(k), $urandom);
        end
        // chunk equals the count: drain all eight
        send_request(aivm_pkg::KIND_EVICT_CHUNK, '0, '0);
        send_request(aivm_pkg::KIND_STORE, 32'hdead_beef, 32'hc000_0000);
        send_request(aivm_pkg::KIND_STORE, 32'h8000_0000, 32'h7f7f_ffff);
        send_request(aivm_pkg::KIND_RESET, 32'h1234_5678, '1);   // clear every valid mark
        send_request(aivm_pkg::KIND_LOAD, 32'hdead_beef, '0);    // gone after the reset
        for (int k = KIND_IGNORED_LOW; k <= KIND_IGNORED_HIGH; k++) begin
            send_request(aivm_pkg::KIND_W'(k), '1, '1);
        end
        send_request(aivm_pkg::KIND_STORE, 32'h0bad_f00d, 32'h0000_0001);

        // A zero chunk drains nothing even from a non-empty table.
        wait_drained();
        write_chunk('0);
        send_request(aivm_pkg::KIND_STORE, 32'h0000_0100, 32'h4049_0fdb);
        send_request(aivm_pkg::KIND_EVICT_CHUNK, 32'hffff_0000, '0);

        // A chunk above the capacity acts as the capacity.
        wait_drained();
        write_chunk('1);
        send_request(aivm_pkg::KIND_STORE, 32'h0000_0200, 32'hbf80_0000);
        send_request(aivm_pkg::KIND_EVICT_CHUNK, 32'h0000_ffff, '0);

        // Random part: two segments per idle phase, a new chunk setting each time.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                // Phase two: the other way round.
                send_idle_pct = 55;
                recv_idle_pct = 28;
            end
            if (seg == 4) begin
                // Phase three: neither side idles.
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            write_chunk(chunk_plan[seg]);
            run_mix(SEGMENT_ITEMS, seg == 1 || seg == 4);
        end

        // Drain, then hold off once more for anything unexpected to show up.
        wait_drained();
        repeat (HOLD_OFF) @(posedge i_clk);
        if (mismatch_total == 0 && results_outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
